>>> sv/uedw_pkg.sv
package uedw_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte0;
      logic [7:0] out_byte1;
      logic [7:0] out_byte2;
      logic [7:0] out_byte3;
      logic [2:0] cell_length;
      logic [1:0] display_width;
      logic       break_after;
      logic       ends_line;
      logic       last_of_run;
   } rsp_type;

   localparam int QDepth = 4;
   localparam int QPtrW  = $clog2(QDepth);
   localparam int CpW    = 21;

   // cells produced by one input byte: up to three width-1 flush cells,
   // then at most one final cell
   typedef struct packed {
      logic [1:0]       flush_count;
      logic [2:0][7:0]  flush_bytes;
      logic             has_cell;
      logic [3:0][7:0]  cell_bytes;
      logic [2:0]       cell_length;
      logic [1:0]       cell_width;
      logic             use_cp;
      logic [CpW-1:0]   code_point;
      logic             break_after;
      logic             ends_line;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   typedef struct packed {
      logic [CpW-1:0] lo;
      logic [CpW-1:0] hi;
   } span_type;

   localparam int NumZeroSpans = 18;
   localparam int NumWideSpans = 13;

   localparam span_type ZeroSpans [NumZeroSpans] = '{
      '{21'h00300, 21'h0036F}, '{21'h00483, 21'h00489}, '{21'h00591, 21'h005BD},
      '{21'h00610, 21'h0061A}, '{21'h0064B, 21'h0065F}, '{21'h00E31, 21'h00E31},
      '{21'h00E34, 21'h00E3A}, '{21'h00E47, 21'h00E4E}, '{21'h00EB1, 21'h00EB1},
      '{21'h00EB4, 21'h00EBC}, '{21'h00EC8, 21'h00ECD}, '{21'h01AB0, 21'h01AFF},
      '{21'h01DC0, 21'h01DFF}, '{21'h0200B, 21'h0200F}, '{21'h020D0, 21'h020FF},
      '{21'h0FE00, 21'h0FE0F}, '{21'h0FE20, 21'h0FE2F}, '{21'h0FEFF, 21'h0FEFF}
   };

   localparam span_type WideSpans [NumWideSpans] = '{
      '{21'h01100, 21'h0115F}, '{21'h02E80, 21'h0303E}, '{21'h03041, 21'h033FF},
      '{21'h03400, 21'h04DBF}, '{21'h04E00, 21'h09FFF}, '{21'h0A000, 21'h0A4CF},
      '{21'h0AC00, 21'h0D7A3}, '{21'h0F900, 21'h0FAFF}, '{21'h0FE30, 21'h0FE4F},
      '{21'h0FF00, 21'h0FF60}, '{21'h0FFE0, 21'h0FFE6}, '{21'h20000, 21'h2FFFD},
      '{21'h30000, 21'h3FFFD}
   };

   function automatic logic [1:0] width_of(input logic [CpW-1:0] cp);
      logic zero_hit;
      logic wide_hit;
      zero_hit = (cp == '0);
      wide_hit = 1'b0;
      for (int i = 0; i < NumZeroSpans; i++) begin
         if (cp >= ZeroSpans[i].lo && cp <= ZeroSpans[i].hi) zero_hit = 1'b1;
      end
      for (int i = 0; i < NumWideSpans; i++) begin
         if (cp >= WideSpans[i].lo && cp <= WideSpans[i].hi) wide_hit = 1'b1;
      end
      if (zero_hit) return 2'd0;
      if (wide_hit) return 2'd2;
      return 2'd1;
   endfunction

endpackage

>>> sv/uedw_front.sv
module uedw_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  uedw_pkg::req_type   req_payload,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data,
   output logic                job_push,
   output uedw_pkg::job_type   job,
   input  uedw_pkg::qstat_type qstat
);

   localparam logic [7:0] ChBel   = 8'h07;
   localparam logic [7:0] ChBs    = 8'h08;
   localparam logic [7:0] ChTab   = 8'h09;
   localparam logic [7:0] ChLf    = 8'h0A;
   localparam logic [7:0] ChVt    = 8'h0B;
   localparam logic [7:0] ChFf    = 8'h0C;
   localparam logic [7:0] ChCr    = 8'h0D;
   localparam logic [7:0] ChSpace = 8'h20;
   localparam logic [7:0] ChQuote = 8'h22;
   localparam logic [7:0] ChSlash = 8'h2F;
   localparam logic [7:0] ChBack  = 8'h5C;

   logic                     utf8_enable_ff;
   logic [7:0]               lead_ff, lead_in;
   logic [2:0]               exp_len_ff, exp_len_in;
   logic [1:0]               cnt_ff, cnt_in;
   logic [uedw_pkg::CpW-1:0] acc_ff, acc_in;
   logic [7:0]               cont_ff [2];
   logic                     cont_wr;

   logic                     accept;
   logic [7:0]               b;
   logic                     eos;
   logic [uedw_pkg::CpW-1:0] acc_cat;
   logic [7:0]               letter;
   logic                     fresh_start;
   logic [2:0]               fresh_len;
   logic [uedw_pkg::CpW-1:0] fresh_bits;
   uedw_pkg::job_type        fresh_job;

   assign b         = req_payload.data_byte;
   assign eos       = req_payload.end_of_string;
   assign req_stall = qstat.full;
   assign accept    = req_valid && !qstat.full;
   assign acc_cat   = {acc_ff[uedw_pkg::CpW-7:0], b[5:0]};

   // byte handled with no sequence pending
   always_comb begin
      case (b)
         ChLf:    letter = "n";
         ChTab:   letter = "t";
         ChCr:    letter = "r";
         ChQuote: letter = "\"";
         ChBack:  letter = "\\";
         ChBel:   letter = "a";
         ChBs:    letter = "b";
         ChFf:    letter = "f";
         ChVt:    letter = "v";
         default: letter = 8'h00;
      endcase

      if (b[7:5] == 3'b110) begin
         fresh_len  = 3'd2;
         fresh_bits = {16'h0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
         fresh_len  = 3'd3;
         fresh_bits = {17'h0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
         fresh_len  = 3'd4;
         fresh_bits = {18'h0, b[2:0]};
      end else begin
         fresh_len  = 3'd0;
         fresh_bits = '0;
      end

      fresh_job                = '0;
      fresh_job.has_cell       = 1'b1;
      fresh_job.cell_bytes[0]  = b;
      fresh_job.cell_length    = 3'd1;
      fresh_job.cell_width     = 2'd1;
      fresh_start              = 1'b0;
      if (letter != 8'h00) begin
         fresh_job.cell_bytes[0] = ChBack;
         fresh_job.cell_bytes[1] = letter;
         fresh_job.cell_length   = 3'd2;
         fresh_job.cell_width    = 2'd2;
         fresh_job.ends_line     = (b == ChLf);
      end else if (b == ChSpace || b == ChSlash) begin
         fresh_job.break_after   = 1'b1;
      end else if (b < ChSpace) begin
         fresh_job.cell_width    = 2'd0;
      end else if (utf8_enable_ff && fresh_len != 3'd0 && !eos) begin
         fresh_start             = 1'b1;
         fresh_job.has_cell      = 1'b0;
      end
   end

   always_comb begin
      lead_in    = lead_ff;
      exp_len_in = exp_len_ff;
      cnt_in     = cnt_ff;
      acc_in     = acc_ff;
      cont_wr    = 1'b0;
      job        = '0;

      if (exp_len_ff != 3'd0 && b[7:6] == 2'b10) begin
         if ({1'b0, cnt_ff} + 3'd2 == exp_len_ff) begin
            job.has_cell      = 1'b1;
            job.cell_bytes[0] = lead_ff;
            job.cell_bytes[1] = (exp_len_ff == 3'd2) ? b : cont_ff[0];
            job.cell_bytes[2] = (exp_len_ff == 3'd3) ? b :
                                (exp_len_ff == 3'd4) ? cont_ff[1] : 8'h00;
            job.cell_bytes[3] = (exp_len_ff == 3'd4) ? b : 8'h00;
            job.cell_length   = exp_len_ff;
            job.use_cp        = 1'b1;
            job.code_point    = acc_cat;
            exp_len_in        = 3'd0;
            cnt_in            = 2'd0;
            acc_in            = '0;
         end else begin
            cont_wr = 1'b1;
            cnt_in  = cnt_ff + 2'd1;
            acc_in  = acc_cat;
            if (eos) begin
               job.flush_count    = cnt_ff + 2'd2;
               job.flush_bytes[0] = lead_ff;
               job.flush_bytes[1] = (cnt_ff == 2'd0) ? b : cont_ff[0];
               job.flush_bytes[2] = b;
               exp_len_in         = 3'd0;
               cnt_in             = 2'd0;
               acc_in             = '0;
            end
         end
      end else begin
         if (exp_len_ff != 3'd0) begin
            // broken sequence: lead and held bytes go out alone
            job.flush_count    = cnt_ff + 2'd1;
            job.flush_bytes[0] = lead_ff;
            job.flush_bytes[1] = cont_ff[0];
            job.flush_bytes[2] = cont_ff[1];
            exp_len_in         = 3'd0;
            cnt_in             = 2'd0;
            acc_in             = '0;
         end
         if (fresh_start) begin
            lead_in    = b;
            exp_len_in = fresh_len;
            cnt_in     = 2'd0;
            acc_in     = fresh_bits;
         end else begin
            job.has_cell    = 1'b1;
            job.cell_bytes  = fresh_job.cell_bytes;
            job.cell_length = fresh_job.cell_length;
            job.cell_width  = fresh_job.cell_width;
            job.break_after = fresh_job.break_after;
            job.ends_line   = fresh_job.ends_line;
         end
      end
   end

   assign job_push = accept && (job.flush_count != 2'd0 || job.has_cell);

   always_ff @(posedge clock) begin
      if (reset) begin
         utf8_enable_ff <= 1'b1;
         lead_ff        <= 8'h00;
         exp_len_ff     <= 3'd0;
         cnt_ff         <= 2'd0;
         acc_ff         <= '0;
      end else begin
         if (csr_wr_en) utf8_enable_ff <= csr_wr_data;
         if (accept) begin
            lead_ff    <= lead_in;
            exp_len_ff <= exp_len_in;
            cnt_ff     <= cnt_in;
            acc_ff     <= acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && cont_wr) cont_ff[cnt_ff[0]] <= b;
   end

endmodule

>>> sv/uedw_queue.sv
module uedw_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  uedw_pkg::job_type   push_job,
   input  logic                pop,
   output uedw_pkg::job_type   head_job,
   output uedw_pkg::qstat_type qstat
);

   uedw_pkg::job_type            q_ff [uedw_pkg::QDepth];
   logic [uedw_pkg::QPtrW-1:0]   wr_ptr_ff;
   logic [uedw_pkg::QPtrW-1:0]   rd_ptr_ff;
   logic [uedw_pkg::QPtrW:0]     count_ff;

   assign head_job    = q_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == (uedw_pkg::QPtrW+1)'(uedw_pkg::QDepth));
   assign qstat.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= push_job;
   end

endmodule

>>> sv/uedw_back.sv
module uedw_back (
   input  logic                clock,
   input  logic                reset,
   input  uedw_pkg::job_type   head_job,
   input  uedw_pkg::qstat_type qstat,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output uedw_pkg::rsp_type   rsp_payload
);

   logic [1:0]        sub_ff, sub_in;
   logic              rsp_valid_ff;
   uedw_pkg::rsp_type rsp_ff, rsp_in;
   logic [2:0]        total;
   logic              last;
   logic              load;
   logic              emit;

   assign total = {1'b0, head_job.flush_count} + {2'b00, head_job.has_cell};
   assign last  = ({1'b0, sub_ff} + 3'd1 == total);
   assign load  = !rsp_valid_ff || !rsp_stall;
   assign emit  = load && !qstat.empty;
   assign pop   = emit && last;
   assign sub_in = last ? 2'd0 : sub_ff + 2'd1;

   always_comb begin
      rsp_in = '0;
      if (sub_ff < head_job.flush_count) begin
         rsp_in.out_byte0     = head_job.flush_bytes[sub_ff];
         rsp_in.cell_length   = 3'd1;
         rsp_in.display_width = 2'd1;
      end else begin
         rsp_in.out_byte0     = head_job.cell_bytes[0];
         rsp_in.out_byte1     = head_job.cell_bytes[1];
         rsp_in.out_byte2     = head_job.cell_bytes[2];
         rsp_in.out_byte3     = head_job.cell_bytes[3];
         rsp_in.cell_length   = head_job.cell_length;
         rsp_in.display_width = head_job.use_cp ? uedw_pkg::width_of(head_job.code_point)
                                                : head_job.cell_width;
         rsp_in.break_after   = head_job.break_after;
         rsp_in.ends_line     = head_job.ends_line;
      end
      rsp_in.last_of_run = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit) sub_ff <= sub_in;
         if (load) rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> sv/utf8_escape_display_width_unit.sv
// Splits a string, one byte per item, into display cells: escapes become
// two-byte backslash forms of width 2, space and slash allow a break, other
// controls have width 0, and with csr_wr_data/utf8 decoding on, a UTF-8
// sequence leaves as one cell whose width comes from the combining and wide
// range tables. Bytes of a broken or cut-off sequence leave as width-1 cells.
// The front end takes one byte per cycle while the queue is not full and
// writes the cells each byte causes as one entry of a 4-entry queue; the
// cell emitter sends one cell per cycle from it while rsp_stall is low. A
// byte may yield up to 4 cells, all sent before its entry is popped; req_stall
// rises only while the queue is full. A byte that only extends a pending
// sequence yields no cell. Cells leave via the queue and the output register.
module utf8_escape_display_width_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  uedw_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output uedw_pkg::rsp_type rsp_payload,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data
);

   logic                job_push;
   uedw_pkg::job_type   push_job;
   uedw_pkg::job_type   head_job;
   logic                job_pop;
   uedw_pkg::qstat_type qstat;

   uedw_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .job_push    (job_push),
      .job         (push_job),
      .qstat       (qstat)
   );

   uedw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .pop      (job_pop),
      .head_job (head_job),
      .qstat    (qstat)
   );

   uedw_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_job    (head_job),
      .qstat       (qstat),
      .pop         (job_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
